// ===== sv/line_angle_snap_macros.svh =====
// ----------------------------------------------------------------------------
// line_angle_snap_macros
// Assertion macros for the line angle snap block. They expand to concurrent
// assertions in simulation and to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_ANGLE_SNAP_MACROS_SVH
`define LINE_ANGLE_SNAP_MACROS_SVH

`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define LAS_CHECK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_angle_snap: check failed");
// The consequent holds after the antecedent, delayed by dly.
`define LAS_CHECK_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("line_angle_snap: delayed check failed");
`else
`define LAS_CHECK_IMPLY(label, ante, cons)
`define LAS_CHECK_DELAY(label, ante, dly, cons)
`endif

`endif

// ===== sv/las_pkg.sv =====
// ----------------------------------------------------------------------------
// las_pkg
// Shared widths, constants, the arctangent table and the CORDIC gain
// table for the line angle snap block.
// ----------------------------------------------------------------------------
package las_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int IDX_OUT_W    = 5;
    localparam int GUARD_BITS   = 14;
    localparam int GAIN_BITS    = 22;
    localparam int CORDIC_W     = 44;
    localparam int ANGLE_W      = 32;
    localparam int ZW           = ANGLE_W + 1;
    localparam int ATAN_ENTRIES = 24;

    localparam int DEF_DIRECTION_COUNT = 24;
    localparam int DEF_CORDIC_STAGES   = 16;

    // atan(2^-i) as a fraction of a full turn, 2^32 = one turn.
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Inverse of the squared CORDIC gain, GAIN_BITS fraction bits, indexed by
    // the stage count. Starting from one, stage k takes floor(g / (4^k + 1))
    // off the running value; past eleven stages nothing more is taken off.
    localparam logic [GAIN_BITS:0] GAIN_BY_STAGES [ATAN_ENTRIES+1] = '{
        23'd4194304, 23'd2097152, 23'd1677722, 23'd1579033, 23'd1554741,
        23'd1548692, 23'd1547182, 23'd1546805, 23'd1546711, 23'd1546688,
        23'd1546683, 23'd1546682, 23'd1546682, 23'd1546682, 23'd1546682,
        23'd1546682, 23'd1546682, 23'd1546682, 23'd1546682, 23'd1546682,
        23'd1546682, 23'd1546682, 23'd1546682, 23'd1546682, 23'd1546682
    };

    typedef enum logic {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } cfg_reg_t;

    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [ZW-1:0]       angle_acc_t;

endpackage

// ===== sv/line_angle_snap.sv =====
// ----------------------------------------------------------------------------
// line_angle_snap
// Snaps the line from the configured origin to a pointer position onto the
// nearest of DIRECTION_COUNT directions, keeping its length. A word is taken
// in every cycle (busy stays low) and its result appears on strobe after the
// vectoring and rotating CORDIC pipelines, one register per micro-rotation,
// plus seven stages for the difference, the pre-rotation, the gain multiply,
// the index rounding, the target lookup, the output rounding and the
// saturating add. The receiver cannot stall, so results leave in order at
// the input rate. Origin writes belong to idle periods.
// ----------------------------------------------------------------------------
`include "line_angle_snap_macros.svh"

module line_angle_snap
    import las_pkg::*;
#(
    parameter int DIRECTION_COUNT = DEF_DIRECTION_COUNT,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_addr,
    input  logic [COORD_W-1:0]         cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    output logic                       strobe,
    output logic signed [COORD_W-1:0]  snapped_x,
    output logic signed [COORD_W-1:0]  snapped_y,
    output logic [IDX_OUT_W-1:0]       direction_index,
    output logic                       clipped
);

    localparam int N       = CORDIC_STAGES;
    localparam int IDX_W   = $clog2(DIRECTION_COUNT + 1);
    localparam int IW      = $clog2(DIRECTION_COUNT);
    localparam int PROD_W  = ANGLE_W + IDX_W;
    localparam int PP_W    = (CORDIC_W - GAIN_BITS) + GAIN_BITS + 1;
    localparam int SHIFT_W = CORDIC_W - GUARD_BITS;
    localparam int SUM_W   = SHIFT_W + 1;
    localparam int LATENCY = 2 * N + 7;
    localparam logic [GAIN_BITS:0] GAIN = GAIN_BY_STAGES[N];
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration registers.
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default:      origin_x_reg <= origin_x_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: difference vector.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic                     s0_valid_reg;

    assign dx_next = DIFF_W'(point_x) - DIFF_W'(origin_x_reg);
    assign dy_next = DIFF_W'(point_y) - DIFF_W'(origin_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
    end

    // Stage 1: scale up and fold the left half plane onto the right one.
    cordic_t    vec_x_reg     [0:N];
    cordic_t    vec_y_reg     [0:N];
    angle_acc_t vec_z_reg     [0:N];
    logic       vec_base_reg  [0:N];
    logic       vec_zero_reg  [0:N];
    logic       vec_valid_reg [0:N];
    cordic_t    prep_x, prep_y;

    assign prep_x = CORDIC_W'(dx_reg) <<< GUARD_BITS;
    assign prep_y = CORDIC_W'(dy_reg) <<< GUARD_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vec_valid_reg[0] <= 1'b0;
        else
            vec_valid_reg[0] <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        vec_x_reg[0]    <= dx_reg[DIFF_W-1] ? -prep_x : prep_x;
        vec_y_reg[0]    <= dx_reg[DIFF_W-1] ? -prep_y : prep_y;
        vec_z_reg[0]    <= '0;
        vec_base_reg[0] <= dx_reg[DIFF_W-1];
        vec_zero_reg[0] <= (dx_reg == '0) && (dy_reg == '0);
    end

    // Vectoring CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam angle_acc_t ATAN_I = ZW'(ATAN_TURNS[i]);
        cordic_t    xs, ys, x_next, y_next;
        angle_acc_t z_next;

        always_comb
        begin
            xs = vec_x_reg[i] >>> i;
            ys = vec_y_reg[i] >>> i;
            if (!vec_y_reg[i][CORDIC_W-1])
            begin
                x_next = vec_x_reg[i] + ys;
                y_next = vec_y_reg[i] - xs;
                z_next = vec_z_reg[i] + ATAN_I;
            end
            else
            begin
                x_next = vec_x_reg[i] - ys;
                y_next = vec_y_reg[i] + xs;
                z_next = vec_z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vec_valid_reg[i+1] <= 1'b0;
            else
                vec_valid_reg[i+1] <= vec_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            vec_x_reg[i+1]    <= x_next;
            vec_y_reg[i+1]    <= y_next;
            vec_z_reg[i+1]    <= z_next;
            vec_base_reg[i+1] <= vec_base_reg[i];
            vec_zero_reg[i+1] <= vec_zero_reg[i];
        end
    end

    // Stage P1: full-turn angle and the two halves of the gain product.
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [PP_W-1:0]    gain_lo_reg, gain_hi_reg;
    logic               p1_zero_reg, p1_valid_reg;

    assign angle_next = {vec_base_reg[N], {(ANGLE_W-1){1'b0}}} + vec_z_reg[N][ANGLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= vec_valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        angle_reg   <= angle_next;
        gain_lo_reg <= PP_W'(vec_x_reg[N][GAIN_BITS-1:0]) * PP_W'(GAIN);
        gain_hi_reg <= PP_W'(vec_x_reg[N][CORDIC_W-1:GAIN_BITS]) * PP_W'(GAIN);
        p1_zero_reg <= vec_zero_reg[N];
    end

    // Stage P2: rounded direction index and the compensated length.
    logic [PROD_W-1:0] idx_prod;
    logic [PP_W-1:0]   len_sum;
    logic [IDX_W-1:0]  idx_raw_reg;
    cordic_t           len_reg;
    logic              p2_zero_reg, p2_valid_reg;

    assign idx_prod = PROD_W'(angle_reg) * PROD_W'(DIRECTION_COUNT)
                    + (PROD_W'(1) << (ANGLE_W - 1));
    assign len_sum  = gain_hi_reg + (gain_lo_reg >> GAIN_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        idx_raw_reg <= idx_prod[PROD_W-1:ANGLE_W];
        len_reg     <= CORDIC_W'(len_sum);
        p2_zero_reg <= p1_zero_reg;
    end

    // Stage P3: wrap the index, look up the target angle, fold into +-quarter turn.
    logic [ANGLE_W-1:0] target_lut [DIRECTION_COUNT];
    logic [IW-1:0]      idx_wrap;
    logic [ANGLE_W-1:0] target, target_fold;
    logic               flip;

    for (genvar d = 0; d < DIRECTION_COUNT; d++)
    begin : g_target
        localparam logic [63:0] TARGET_D = (64'(d) << ANGLE_W) / DIRECTION_COUNT;
        assign target_lut[d] = TARGET_D[ANGLE_W-1:0];
    end

    assign idx_wrap    = (p2_zero_reg || idx_raw_reg == IDX_W'(DIRECTION_COUNT))
                       ? '0 : idx_raw_reg[IW-1:0];
    assign target      = target_lut[idx_wrap];
    assign flip        = target[ANGLE_W-1] ^ target[ANGLE_W-2];
    assign target_fold = {target[ANGLE_W-1] ^ flip, target[ANGLE_W-2:0]};

    cordic_t       rot_x_reg     [0:N];
    cordic_t       rot_y_reg     [0:N];
    angle_acc_t    rot_z_reg     [0:N];
    logic          rot_flip_reg  [0:N];
    logic [IW-1:0] rot_idx_reg   [0:N];
    logic          rot_valid_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_valid_reg[0] <= 1'b0;
        else
            rot_valid_reg[0] <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg[0]    <= len_reg;
        rot_y_reg[0]    <= '0;
        rot_z_reg[0]    <= ZW'($signed(target_fold));
        rot_flip_reg[0] <= flip;
        rot_idx_reg[0]  <= idx_wrap;
    end

    // Rotating CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam angle_acc_t ATAN_I = ZW'(ATAN_TURNS[i]);
        cordic_t    xs, ys, x_next, y_next;
        angle_acc_t z_next;

        always_comb
        begin
            xs = rot_x_reg[i] >>> i;
            ys = rot_y_reg[i] >>> i;
            if (!rot_z_reg[i][ZW-1])
            begin
                x_next = rot_x_reg[i] - ys;
                y_next = rot_y_reg[i] + xs;
                z_next = rot_z_reg[i] - ATAN_I;
            end
            else
            begin
                x_next = rot_x_reg[i] + ys;
                y_next = rot_y_reg[i] - xs;
                z_next = rot_z_reg[i] + ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rot_valid_reg[i+1] <= 1'b0;
            else
                rot_valid_reg[i+1] <= rot_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            rot_x_reg[i+1]    <= x_next;
            rot_y_reg[i+1]    <= y_next;
            rot_z_reg[i+1]    <= z_next;
            rot_flip_reg[i+1] <= rot_flip_reg[i];
            rot_idx_reg[i+1]  <= rot_idx_reg[i];
        end
    end

    // Stage O1: undo the fold and round half up out of the guard bits.
    // For a folded target, -v + half is computed as ~v + half + 1.
    localparam cordic_t HALF     = cordic_t'(1) <<< (GUARD_BITS - 1);
    localparam cordic_t HALF_INC = HALF + cordic_t'(1);
    cordic_t                  fold_x, fold_y;
    logic signed [SHIFT_W-1:0] rnd_x_reg, rnd_y_reg;
    logic [IW-1:0]            o1_idx_reg;
    logic                     o1_valid_reg;

    assign fold_x = rot_flip_reg[N] ? (~rot_x_reg[N] + HALF_INC) : (rot_x_reg[N] + HALF);
    assign fold_y = rot_flip_reg[N] ? (~rot_y_reg[N] + HALF_INC) : (rot_y_reg[N] + HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o1_valid_reg <= 1'b0;
        else
            o1_valid_reg <= rot_valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        rnd_x_reg  <= SHIFT_W'(fold_x >>> GUARD_BITS);
        rnd_y_reg  <= SHIFT_W'(fold_y >>> GUARD_BITS);
        o1_idx_reg <= rot_idx_reg[N];
    end

    // Stage O2: add the origin and saturate to the coordinate range.
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic                      ovf_x, ovf_y;
    logic signed [COORD_W-1:0] sat_x_next, sat_y_next;
    logic signed [COORD_W-1:0] snapped_x_reg, snapped_y_reg;
    logic [IDX_OUT_W-1:0]      direction_index_reg;
    logic                      clipped_reg, strobe_reg;

    assign sum_x = SUM_W'(rnd_x_reg) + SUM_W'(origin_x_reg);
    assign sum_y = SUM_W'(rnd_y_reg) + SUM_W'(origin_y_reg);
    assign ovf_x = !((&sum_x[SUM_W-1:COORD_W-1]) || !(|sum_x[SUM_W-1:COORD_W-1]));
    assign ovf_y = !((&sum_y[SUM_W-1:COORD_W-1]) || !(|sum_y[SUM_W-1:COORD_W-1]));
    assign sat_x_next = ovf_x ? (sum_x[SUM_W-1] ? COORD_MIN : COORD_MAX) : sum_x[COORD_W-1:0];
    assign sat_y_next = ovf_y ? (sum_y[SUM_W-1] ? COORD_MIN : COORD_MAX) : sum_y[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= o1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        snapped_x_reg       <= sat_x_next;
        snapped_y_reg       <= sat_y_next;
        direction_index_reg <= IDX_OUT_W'(o1_idx_reg);
        clipped_reg         <= ovf_x || ovf_y;
    end

    assign strobe          = strobe_reg;
    assign snapped_x       = snapped_x_reg;
    assign snapped_y       = snapped_y_reg;
    assign direction_index = direction_index_reg;
    assign clipped         = clipped_reg;

    // Every accepted word leaves after the fixed pipeline latency.
    `LAS_CHECK_DELAY(a_fixed_latency, start && !busy, LATENCY, strobe)
    // The chosen direction always names one of the configured directions.
    `LAS_CHECK_IMPLY(a_index_range, strobe, 32'(direction_index) < DIRECTION_COUNT)
    // A clipped result carries a coordinate pinned at one end of the range.
    `LAS_CHECK_IMPLY(a_clip_pinned, strobe && clipped, snapped_x == COORD_MAX || snapped_x == COORD_MIN || snapped_y == COORD_MAX || snapped_y == COORD_MIN)

endmodule

// ===== dv/tb_line_angle_snap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_angle_snap
// Self-checking bench for the line angle snap block. A queue of pointer words
// feeds a driver with random idle bursts. Each accepted word is run through a
// bit-exact CORDIC predictor, and the monitor checks every strobed result
// against the oldest prediction. The origin is rewritten between phases,
// covering the reset value, both extremes and random settings.
// ----------------------------------------------------------------------------
module tb_line_angle_snap;
    import las_pkg::*;

    localparam int     DIR_COUNT      = 24;
    localparam int     STAGE_COUNT    = 16;
    localparam int     PIPE_LATENCY   = 2 * STAGE_COUNT + 7;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PRINT_LIMIT    = 40;
    localparam longint COORD_MAX      = 64'sd8388607;
    localparam longint COORD_MIN      = -64'sd8388608;

    // atan(2^-i) in turns, 2^32 per full turn.
    localparam longint ATAN_STEP [0:STAGE_COUNT-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        int unsigned               idle_odds;
    } pointer_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_OUT_W-1:0]      dir;
        logic                      clip;
    } snap_result_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    cfg_reg_t                  cfg_addr  = REG_ORIGIN_X;
    logic [COORD_W-1:0]        cfg_wdata = '0;
    logic                      start     = 1'b0;
    logic signed [COORD_W-1:0] point_x   = '0;
    logic signed [COORD_W-1:0] point_y   = '0;
    logic                      busy;
    logic                      strobe;
    logic signed [COORD_W-1:0] snapped_x;
    logic signed [COORD_W-1:0] snapped_y;
    logic [IDX_OUT_W-1:0]      direction_index;
    logic                      clipped;

    pointer_word_t pending_words [$];
    snap_result_t  snap_expect [$];
    pointer_word_t drive_word;
    snap_result_t  want;

    logic signed [COORD_W-1:0] origin_x_q = '0;
    logic signed [COORD_W-1:0] origin_y_q = '0;

    int unsigned send_gap     = 0;
    int unsigned idle_cycles  = 0;
    int unsigned mismatches   = 0;
    int unsigned words_in     = 0;
    int unsigned results_out  = 0;
    int unsigned clipped_seen = 0;
    int unsigned zero_seen    = 0;
    logic [DIR_COUNT-1:0] dirs_seen = '0;

    line_angle_snap #(
        .DIRECTION_COUNT (DIR_COUNT),
        .CORDIC_STAGES   (STAGE_COUNT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .point_x         (point_x),
        .point_y         (point_y),
        .strobe          (strobe),
        .snapped_x       (snapped_x),
        .snapped_y       (snapped_y),
        .direction_index (direction_index),
        .clipped         (clipped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [COORD_W-1:0] sat24(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        if (v < COORD_MIN)
            return COORD_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // Snapped end point for one pointer word under the given origin.
    function automatic snap_result_t predict_snap(input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py,
                                                  input logic signed [COORD_W-1:0] ox,
                                                  input logic signed [COORD_W-1:0] oy);
        longint            dx, dy, x, y, z, xs, ys, sum, r, rx, ry, rz, end_x, end_y;
        longint unsigned   g, idx, t64, xu;
        logic [31:0]       angle, t;
        logic              flip;
        snap_result_t      res;
        dx = longint'(px) - longint'(ox);
        dy = longint'(py) - longint'(oy);
        if (dx == 0 && dy == 0)
        begin
            res.x    = ox;
            res.y    = oy;
            res.dir  = '0;
            res.clip = 1'b0;
            return res;
        end
        // Vectoring: fold the left half plane over, then drive y to zero.
        x = dx <<< GUARD_BITS;
        y = dy <<< GUARD_BITS;
        z = 0;
        sum = 0;
        if (x < 0)
        begin
            x   = -x;
            y   = -y;
            sum = 64'sh8000_0000;
        end
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        sum   = sum + z;
        angle = sum[31:0];
        idx   = ({32'd0, angle} * DIR_COUNT + 64'h8000_0000) >> 32;
        if (idx >= DIR_COUNT)
            idx = 0;
        // The vector length carries the squared CORDIC gain; take it out.
        g = 64'd1 << GAIN_BITS;
        for (int i = 0; i < STAGE_COUNT; i++)
            g = g - g / ((64'd1 << (2 * i)) + 64'd1);
        xu = x;
        r  = (xu * g) >> GAIN_BITS;
        // Rotation toward the chosen direction, targets in the left half
        // plane are turned by half a turn and negated afterwards.
        t64  = (idx << 32) / DIR_COUNT;
        t    = t64[31:0];
        flip = 1'b0;
        if (t >= 32'h4000_0000 && t < 32'hC000_0000)
        begin
            t    = t - 32'h8000_0000;
            flip = 1'b1;
        end
        rz = longint'($signed(t));
        rx = r;
        ry = 0;
        for (int i = 0; i < STAGE_COUNT; i++)
        begin
            xs = rx >>> i;
            ys = ry >>> i;
            if (rz >= 0)
            begin
                rx = rx - ys;
                ry = ry + xs;
                rz = rz - ATAN_STEP[i];
            end
            else
            begin
                rx = rx + ys;
                ry = ry - xs;
                rz = rz + ATAN_STEP[i];
            end
        end
        if (flip)
        begin
            rx = -rx;
            ry = -ry;
        end
        end_x = longint'(ox) + ((rx + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
        end_y = longint'(oy) + ((ry + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
        res.x    = sat24(end_x);
        res.y    = sat24(end_y);
        res.dir  = idx[IDX_OUT_W-1:0];
        res.clip = (end_x > COORD_MAX) || (end_x < COORD_MIN) ||
                   (end_y > COORD_MAX) || (end_y < COORD_MIN);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on result %0d: %s", $time, results_out, what);
    endtask

    task automatic queue_point(input longint x, input longint y, input int unsigned odds);
        pointer_word_t w;
        w.x         = sat24(x);
        w.y         = sat24(y);
        w.idle_odds = odds;
        pending_words.push_back(w);
    endtask

    // Random words around the current origin: full range, short and medium
    // vectors, and vectors hugging an axis (where the index wraps).
    task automatic queue_random(input int count, input longint ox, input longint oy,
                                input logic quiet);
        logic [COORD_W-1:0] raw_x, raw_y;
        longint             px, py;
        int unsigned        odds;
        odds = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k % 25 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: odds = 0;
                    1: odds = 2;
                    default: odds = 6;
                endcase
                if (quiet)
                    odds = 0;
            end
            raw_x = COORD_W'($urandom);
            raw_y = COORD_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    px = longint'($signed(raw_x));
                    py = longint'($signed(raw_y));
                end
                3, 4, 5:
                begin
                    px = ox + longint'($urandom_range(0, 128)) - 64;
                    py = oy + longint'($urandom_range(0, 128)) - 64;
                end
                6, 7:
                begin
                    px = ox + longint'($urandom_range(0, 131072)) - 65536;
                    py = oy + longint'($urandom_range(0, 131072)) - 65536;
                end
                8:
                begin
                    px = ox + longint'($signed(raw_x));
                    py = oy + longint'($urandom_range(0, 6)) - 3;
                end
                default:
                begin
                    px = ox + longint'($urandom_range(0, 6)) - 3;
                    py = oy + longint'($signed(raw_y));
                end
            endcase
            queue_point(px, py, odds);
        end
    endtask

    task automatic write_origin(input logic signed [COORD_W-1:0] ox,
                                input logic signed [COORD_W-1:0] oy);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= REG_ORIGIN_X;
        cfg_wdata <= ox;
        @(posedge clk);
        cfg_addr  <= REG_ORIGIN_Y;
        cfg_wdata <= oy;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Returns once every queued word is taken and every result is back.
    task automatic drain();
        @(posedge clk);
        while (pending_words.size() != 0 || start || snap_expect.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Origin shadow, updated at the same edge the block takes the write.
    always @(posedge clk)
    begin
        if (rst_n && cfg_write)
        begin
            case (cfg_addr)
                REG_ORIGIN_X: origin_x_q <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
            endcase
        end
    end

    // Driver: presents one word at a time, holds it while busy.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                snap_expect.push_back(predict_snap(point_x, point_y, origin_x_q, origin_y_q));
                words_in++;
            end
            if (start && busy)
            begin
                // The word stays on the bus until it is taken.
            end
            else if (send_gap != 0)
            begin
                start    <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (pending_words.size() != 0)
            begin
                drive_word = pending_words.pop_front();
                point_x <= drive_word.x;
                point_y <= drive_word.y;
                start   <= 1'b1;
                if (drive_word.idle_odds != 0 && $urandom_range(1, drive_word.idle_odds) == 1)
                    send_gap = $urandom_range(1, 18);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (snap_expect.size() == 0)
            begin
                report_mismatch("result strobed with no word outstanding");
            end
            else
            begin
                want = snap_expect.pop_front();
                if (snapped_x !== want.x)
                    report_mismatch($sformatf("snapped_x %0d, predicted %0d", snapped_x, want.x));
                if (snapped_y !== want.y)
                    report_mismatch($sformatf("snapped_y %0d, predicted %0d", snapped_y, want.y));
                if (direction_index !== want.dir)
                    report_mismatch($sformatf("direction_index %0d, predicted %0d",
                                              direction_index, want.dir));
                if (clipped !== want.clip)
                    report_mismatch($sformatf("clipped %0b, predicted %0b", clipped, want.clip));
                if (want.clip)
                    clipped_seen++;
                if (want.dir < DIR_COUNT)
                    dirs_seen[want.dir] = 1'b1;
            end
            results_out++;
        end
    end

    // Watchdog on cycles where neither side moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset origin: axes, the zero vector, the wrap just below +x, the
        // field extremes and a long vector that saturates.
        queue_point(0, 0, 0);
        queue_point(16, 0, 0);
        queue_point(0, 16, 3);
        queue_point(-16, 0, 0);
        queue_point(0, -16, 3);
        queue_point(1000, -1, 0);
        queue_point(100, -1, 0);
        queue_point(1, 1, 3);
        queue_point(-1, 1, 0);
        queue_point(COORD_MAX, COORD_MAX, 0);
        queue_point(COORD_MIN, COORD_MIN, 3);
        queue_point(COORD_MAX, COORD_MIN, 0);
        queue_point(COORD_MIN, COORD_MAX, 0);
        queue_point(COORD_MAX, 0, 3);
        queue_point(COORD_MIN, 0, 0);
        queue_point(0, COORD_MIN, 0);
        queue_point(COORD_MAX, 5000000, 0);
        zero_seen++;
        queue_random(60, 0, 0, 1'b0);
        drain();

        write_origin(COORD_MIN[COORD_W-1:0], COORD_MIN[COORD_W-1:0]);
        queue_point(COORD_MAX, COORD_MAX, 0);
        queue_point(COORD_MIN, COORD_MIN, 0);
        queue_point(COORD_MIN, COORD_MAX, 3);
        zero_seen++;
        queue_random(70, COORD_MIN, COORD_MIN, 1'b0);
        drain();

        write_origin(COORD_MAX[COORD_W-1:0], COORD_MIN[COORD_W-1:0]);
        queue_point(COORD_MIN, COORD_MAX, 0);
        queue_point(COORD_MAX, COORD_MIN, 0);
        zero_seen++;
        queue_random(70, COORD_MAX, COORD_MIN, 1'b0);
        drain();

        write_origin(COORD_W'($urandom), COORD_W'($urandom));
        queue_random(70, longint'(origin_x_q), longint'(origin_y_q), 1'b0);
        drain();

        write_origin(COORD_MAX[COORD_W-1:0], COORD_MAX[COORD_W-1:0]);
        queue_random(60, COORD_MAX, COORD_MAX, 1'b0);
        drain();

        // Closing stretch runs back to back with no idle cycles.
        write_origin('0, '0);
        queue_random(70, 0, 0, 1'b1);
        drain();

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (snap_expect.size() != 0)
            report_mismatch($sformatf("%0d predictions never came back", snap_expect.size()));

        $display("%0d words sent and %0d results checked over 6 origin settings",
                 words_in, results_out);
        $display("%0d of %0d directions reached, %0d saturated, %0d directed zero-length",
                 $countones(dirs_seen), DIR_COUNT, clipped_seen, zero_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
